// File: sv/rmb_pkg.sv
// rmb_pkg: shared types, sizes and codes for the response match buffer
// used by every module of the block except rmb_ram; depends on nothing
package rmb_pkg;

  localparam int PENDING_DEPTH = 8;
  localparam int PAYLOAD_MAX   = 32;

  localparam int SLOT_NUM   = PENDING_DEPTH + 1;
  localparam int SLOT_W     = $clog2(SLOT_NUM);
  localparam int PEND_IDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int CNT_W      = $clog2(PENDING_DEPTH + 1);
  localparam int PAY_IDX_W  = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
  localparam int PAY_ADDR_W = SLOT_W + PAY_IDX_W;
  localparam int PAY_DEPTH  = SLOT_NUM * (2 ** PAY_IDX_W);
  localparam int LEN_W      = 6;
  localparam int CFG_IDX_W  = 2;

  localparam logic [LEN_W-1:0] PAYLOAD_MAX_LEN = LEN_W'(PAYLOAD_MAX);
  localparam logic [CNT_W-1:0] PENDING_FULL    = CNT_W'(PENDING_DEPTH);

  // action codes
  localparam logic [1:0] ACT_HEADER = 2'd0;
  localparam logic [1:0] ACT_BYTE   = 2'd1;
  localparam logic [1:0] ACT_TAKE   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PUSH_SET   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PUSH_PARAM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PUSH_CALIB = 2'd2;

  // register reset values
  localparam logic [7:0] PUSH_SET_RST   = 8'h0E;
  localparam logic [7:0] PUSH_PARAM_RST = 8'h08;
  localparam logic [7:0] PUSH_CALIB_RST = 8'h10;

  typedef struct packed {
    logic [1:0]       action;
    logic [15:0]      seq;
    logic [7:0]       command_set;
    logic [7:0]       command_id;
    logic             is_response;
    logic [LEN_W-1:0] msg_length;
    logic [7:0]       payload_byte;
    logic [7:0]       out_limit;
  } in_data_t;

  typedef struct packed {
    logic             kind;
    logic             found;
    logic [7:0]       code;
    logic             code_missing;
    logic [LEN_W-1:0] out_length;
    logic [7:0]       data_byte;
    logic             last;
  } out_data_t;

  typedef struct packed {
    logic [15:0]      seq;
    logic [7:0]       cset;
    logic [7:0]       cid;
    logic [LEN_W-1:0] length;
  } key_word_t;

  typedef struct packed {
    logic                  remove;
    logic [PEND_IDX_W-1:0] pos;
  } take_rm_t;

  typedef struct packed {
    logic [PENDING_DEPTH-1:0][SLOT_W-1:0] order;
    logic [CNT_W-1:0]                     count;
    logic [SLOT_W-1:0]                    build_slot;
  } slot_stat_t;

  typedef enum logic [2:0] {
    TK_IDLE,
    TK_READ,
    TK_CMP,
    TK_CODE,
    TK_STAT,
    TK_BYTE
  } take_state_t;

endpackage

// File: sv/rmb_ram.sv
// rmb_ram: generic single write, single read ram with registered read data
// no dependencies
module rmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/rmb_slots.sv
// rmb_slots: age order of pending entries over physical ram slots, plus the spare build slot
// depends on rmb_pkg
module rmb_slots (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                append,
  input  rmb_pkg::take_rm_t   rm,
  output rmb_pkg::slot_stat_t stat
);

  logic [rmb_pkg::PENDING_DEPTH-1:0][rmb_pkg::SLOT_W-1:0] order_r, order_nxt;
  logic [rmb_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [rmb_pkg::SLOT_NUM-1:0] used_r, used_nxt;
  logic [rmb_pkg::SLOT_W-1:0]   build_slot_r, build_slot_nxt;
  logic [rmb_pkg::SLOT_NUM-1:0] taken;
  logic [rmb_pkg::SLOT_W-1:0]   free_slot;

  always_comb begin
    order_nxt      = order_r;
    count_nxt      = count_r;
    used_nxt       = used_r;
    build_slot_nxt = build_slot_r;
    taken          = used_r;
    taken[build_slot_r] = 1'b1;
    // lowest slot neither pending nor under build
    free_slot = build_slot_r;
    for (int s = rmb_pkg::SLOT_NUM - 1; s >= 0; s--) begin
      if (!taken[s]) begin
        free_slot = rmb_pkg::SLOT_W'(s);
      end
    end
    if (append) begin
      if (count_r == rmb_pkg::PENDING_FULL) begin
        // full: oldest drops out, its slot becomes the new build slot
        for (int m = 0; m < rmb_pkg::PENDING_DEPTH - 1; m++) begin
          order_nxt[m] = order_r[m+1];
        end
        order_nxt[rmb_pkg::PENDING_DEPTH-1] = build_slot_r;
        used_nxt[order_r[0]]  = 1'b0;
        used_nxt[build_slot_r] = 1'b1;
        build_slot_nxt = order_r[0];
      end else begin
        order_nxt[count_r[rmb_pkg::PEND_IDX_W-1:0]] = build_slot_r;
        count_nxt = count_r + 1'b1;
        used_nxt[build_slot_r] = 1'b1;
        build_slot_nxt = free_slot;
      end
    end else if (rm.remove) begin
      for (int m = 0; m < rmb_pkg::PENDING_DEPTH - 1; m++) begin
        if (rmb_pkg::PEND_IDX_W'(m) >= rm.pos) begin
          order_nxt[m] = order_r[m+1];
        end
      end
      used_nxt[order_r[rm.pos]] = 1'b0;
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r      <= '0;
      count_r      <= '0;
      used_r       <= '0;
      build_slot_r <= '0;
    end else begin
      order_r      <= order_nxt;
      count_r      <= count_nxt;
      used_r       <= used_nxt;
      build_slot_r <= build_slot_nxt;
    end
  end

  assign stat.order      = order_r;
  assign stat.count      = count_r;
  assign stat.build_slot = build_slot_r;

endmodule

// File: sv/rmb_take.sv
// rmb_take: take sequencer, scans keys oldest first and streams the matching payload
// depends on rmb_pkg; drives the read ports of the key and payload rams
module rmb_take (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                take_go,
  input  rmb_pkg::in_data_t                   in_key,
  input  rmb_pkg::slot_stat_t                 stat,
  input  rmb_pkg::key_word_t                  key_rdata,
  input  logic [7:0]                          pay_rdata,
  output logic                                key_re,
  output logic [rmb_pkg::SLOT_W-1:0]          key_raddr,
  output logic                                pay_re,
  output logic [rmb_pkg::PAY_ADDR_W-1:0]      pay_raddr,
  output rmb_pkg::take_rm_t                   rm,
  output logic                                busy,
  output logic                                out_valid,
  output rmb_pkg::out_data_t                  out_data
);

  rmb_pkg::take_state_t state_r, state_nxt;

  logic [rmb_pkg::CNT_W-1:0]      k_r;
  logic [15:0]                    key_seq_r;
  logic [7:0]                     key_set_r;
  logic [7:0]                     key_id_r;
  logic [7:0]                     lim_r;
  logic [rmb_pkg::SLOT_W-1:0]     slot_r;
  logic [rmb_pkg::PEND_IDX_W-1:0] pos_r;
  logic [rmb_pkg::LEN_W-1:0]      elen_r;
  logic [rmb_pkg::LEN_W-1:0]      n_r;
  logic [rmb_pkg::LEN_W-1:0]      j_r;
  logic                           out_valid_r, out_valid_nxt;
  rmb_pkg::out_data_t             out_data_r, out_data_nxt;

  logic [rmb_pkg::SLOT_W-1:0] cur_slot;
  logic                       miss;
  logic                       hit;
  logic [rmb_pkg::LEN_W-1:0]  n_calc;
  logic [rmb_pkg::LEN_W-1:0]  j_inc;
  logic                       last_byte;

  assign cur_slot  = stat.order[k_r[rmb_pkg::PEND_IDX_W-1:0]];
  assign miss      = (k_r >= stat.count);
  assign hit       = (key_rdata.seq == key_seq_r) && (key_rdata.cset == key_set_r) &&
                     (key_rdata.cid == key_id_r);
  assign n_calc    = (8'(key_rdata.length) > lim_r) ? lim_r[rmb_pkg::LEN_W-1:0]
                                                    : key_rdata.length;
  assign j_inc     = j_r + 1'b1;
  assign last_byte = (j_inc == n_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rmb_pkg::TK_IDLE: begin
        if (take_go) begin
          state_nxt = rmb_pkg::TK_READ;
        end
      end
      rmb_pkg::TK_READ: begin
        state_nxt = miss ? rmb_pkg::TK_IDLE : rmb_pkg::TK_CMP;
      end
      rmb_pkg::TK_CMP: begin
        state_nxt = hit ? rmb_pkg::TK_CODE : rmb_pkg::TK_READ;
      end
      rmb_pkg::TK_CODE: begin
        state_nxt = rmb_pkg::TK_STAT;
      end
      rmb_pkg::TK_STAT: begin
        state_nxt = (n_r == '0) ? rmb_pkg::TK_IDLE : rmb_pkg::TK_BYTE;
      end
      rmb_pkg::TK_BYTE: begin
        state_nxt = last_byte ? rmb_pkg::TK_IDLE : rmb_pkg::TK_BYTE;
      end
      default: begin
        state_nxt = rmb_pkg::TK_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    key_re        = 1'b0;
    key_raddr     = cur_slot;
    pay_re        = 1'b0;
    pay_raddr     = {slot_r, rmb_pkg::PAY_IDX_W'(0)};
    rm.remove     = 1'b0;
    rm.pos        = pos_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = '0;
    unique case (state_r)
      rmb_pkg::TK_IDLE: begin
      end
      rmb_pkg::TK_READ: begin
        if (miss) begin
          out_valid_nxt     = 1'b1;
          out_data_nxt.last = 1'b1;
        end else begin
          key_re = 1'b1;
        end
      end
      rmb_pkg::TK_CMP: begin
      end
      rmb_pkg::TK_CODE: begin
        pay_re = 1'b1;
      end
      rmb_pkg::TK_STAT: begin
        out_valid_nxt             = 1'b1;
        out_data_nxt.found        = 1'b1;
        out_data_nxt.code         = (elen_r != '0) ? pay_rdata : 8'd0;
        out_data_nxt.code_missing = (elen_r == '0);
        out_data_nxt.out_length   = n_r;
        out_data_nxt.last         = (n_r == '0);
        pay_re                    = 1'b1;
        rm.remove                 = (n_r == '0);
      end
      rmb_pkg::TK_BYTE: begin
        out_valid_nxt          = 1'b1;
        out_data_nxt.kind      = 1'b1;
        out_data_nxt.found     = 1'b1;
        out_data_nxt.data_byte = pay_rdata;
        out_data_nxt.last      = last_byte;
        pay_re                 = 1'b1;
        pay_raddr              = {slot_r, j_inc[rmb_pkg::PAY_IDX_W-1:0]};
        rm.remove              = last_byte;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rmb_pkg::TK_IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == rmb_pkg::TK_IDLE) begin
        k_r <= '0;
      end else if (state_r == rmb_pkg::TK_CMP && !hit) begin
        k_r <= k_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (state_r == rmb_pkg::TK_IDLE && take_go) begin
      key_seq_r <= in_key.seq;
      key_set_r <= in_key.command_set;
      key_id_r  <= in_key.command_id;
      lim_r     <= in_key.out_limit;
    end
    if (state_r == rmb_pkg::TK_CMP && hit) begin
      slot_r <= cur_slot;
      pos_r  <= k_r[rmb_pkg::PEND_IDX_W-1:0];
      elen_r <= key_rdata.length;
      n_r    <= n_calc;
    end
    if (state_r == rmb_pkg::TK_STAT) begin
      j_r <= '0;
    end else if (state_r == rmb_pkg::TK_BYTE) begin
      j_r <= j_inc;
    end
  end

  assign busy      = (state_r != rmb_pkg::TK_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: sv/response_match_buffer.sv
// response_match_buffer: top level, message assembly, push filtering and config registers
// depends on rmb_pkg, rmb_ram, rmb_slots and rmb_take
//
// usage
//   input words go in on in_data with start; a word is taken when start is high and busy
//   is low. action header opens a message, action byte adds one payload byte, action take
//   asks for the oldest buffered response whose seq, set and id match.
//   header and byte words leave busy low, so one can follow every cycle while no take
//   runs. a completed response is written to a free ram slot; push messages and
//   non-response frames are dropped, and a full buffer drops its oldest entry.
//   a take holds busy high while it runs: for each entry scanned it reads the key ram,
//   then compares; on a match it fetches the code byte, then streams the payload bytes.
//   the key ram's registered read data is why the scan loop has a read step and then a
//   compare step for each entry. results leave on out_data, one cycle each, strobed by
//   out_valid in the cycle after the sequencer step that made them; the receiver cannot
//   stall, and last marks the final word of a take.
//   config writes use cfg_valid/cfg_ready (always ready), indexes 0..2; others are ignored.
//   reset (rst_n low, synchronous) empties the buffer and drops any partial message; the
//   rams are not cleared, since data read from a location never written is never used.
module response_match_buffer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  rmb_pkg::in_data_t                 in_data,
  output logic                              out_valid,
  output rmb_pkg::out_data_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rmb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [7:0]                        cfg_data
);

  // push filter registers
  logic [7:0] push_set_r;
  logic [7:0] push_param_r;
  logic [7:0] push_calib_r;

  // message under assembly
  rmb_pkg::key_word_t        bld_key_r;
  logic                      bld_resp_r;
  logic [rmb_pkg::LEN_W-1:0] bld_idx_r;
  logic                      bld_active_r;

  logic                      acc;
  logic                      hdr_go;
  logic                      byte_go;
  logic                      take_go;
  logic [rmb_pkg::LEN_W-1:0] len_sat;
  logic [rmb_pkg::LEN_W-1:0] idx_inc;
  logic                      hdr_done;
  logic                      byte_done;
  rmb_pkg::key_word_t        disp_key;
  logic                      disp_resp;
  logic                      is_push;
  logic                      keep;

  rmb_pkg::slot_stat_t slot_stat;
  rmb_pkg::take_rm_t   take_rm;

  logic                           key_re;
  logic [rmb_pkg::SLOT_W-1:0]     key_raddr;
  rmb_pkg::key_word_t             key_rdata;
  logic                           pay_re;
  logic [rmb_pkg::PAY_ADDR_W-1:0] pay_raddr;
  logic [rmb_pkg::PAY_ADDR_W-1:0] pay_waddr;
  logic [7:0]                     pay_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      push_set_r   <= rmb_pkg::PUSH_SET_RST;
      push_param_r <= rmb_pkg::PUSH_PARAM_RST;
      push_calib_r <= rmb_pkg::PUSH_CALIB_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rmb_pkg::REG_PUSH_SET:   push_set_r   <= cfg_data;
        rmb_pkg::REG_PUSH_PARAM: push_param_r <= cfg_data;
        rmb_pkg::REG_PUSH_CALIB: push_calib_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // word decode
  assign acc     = start && !busy;
  assign hdr_go  = acc && (in_data.action == rmb_pkg::ACT_HEADER);
  assign byte_go = acc && (in_data.action == rmb_pkg::ACT_BYTE) && bld_active_r &&
                   (bld_idx_r < rmb_pkg::PAYLOAD_MAX_LEN);
  assign take_go = acc && (in_data.action == rmb_pkg::ACT_TAKE);

  // over-long messages are cut at the payload limit
  assign len_sat = (in_data.msg_length > rmb_pkg::PAYLOAD_MAX_LEN) ?
                   rmb_pkg::PAYLOAD_MAX_LEN : in_data.msg_length;
  assign idx_inc = bld_idx_r + 1'b1;

  // a message completes at an empty header or at its last payload byte
  assign hdr_done  = hdr_go && (len_sat == '0);
  assign byte_done = byte_go && (idx_inc >= bld_key_r.length);

  always_comb begin
    if (hdr_go) begin
      disp_key.seq    = in_data.seq;
      disp_key.cset   = in_data.command_set;
      disp_key.cid    = in_data.command_id;
      disp_key.length = len_sat;
      disp_resp       = in_data.is_response;
    end else begin
      disp_key  = bld_key_r;
      disp_resp = bld_resp_r;
    end
  end

  assign is_push = (disp_key.cset == push_set_r) &&
                   ((disp_key.cid == push_param_r) || (disp_key.cid == push_calib_r));
  assign keep    = (hdr_done || byte_done) && disp_resp && !is_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bld_key_r    <= '0;
      bld_resp_r   <= 1'b0;
      bld_idx_r    <= '0;
      bld_active_r <= 1'b0;
    end else if (hdr_go) begin
      bld_key_r    <= disp_key;
      bld_resp_r   <= in_data.is_response;
      bld_idx_r    <= '0;
      bld_active_r <= (len_sat != '0);
    end else if (byte_go) begin
      if (byte_done) begin
        bld_idx_r    <= '0;
        bld_active_r <= 1'b0;
      end else begin
        bld_idx_r <= idx_inc;
      end
    end
  end

  // payload bytes land straight in the spare slot; on keep that slot joins the queue
  assign pay_waddr = {slot_stat.build_slot, bld_idx_r[rmb_pkg::PAY_IDX_W-1:0]};

  rmb_ram #(
    .WIDTH ($bits(rmb_pkg::key_word_t)),
    .DEPTH (rmb_pkg::SLOT_NUM)
  ) u_key_ram (
    .clk   (clk),
    .we    (keep),
    .waddr (slot_stat.build_slot),
    .wdata (disp_key),
    .re    (key_re),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  rmb_ram #(
    .WIDTH (8),
    .DEPTH (rmb_pkg::PAY_DEPTH)
  ) u_pay_ram (
    .clk   (clk),
    .we    (byte_go),
    .waddr (pay_waddr),
    .wdata (in_data.payload_byte),
    .re    (pay_re),
    .raddr (pay_raddr),
    .rdata (pay_rdata)
  );

  rmb_slots u_slots (
    .clk    (clk),
    .rst_n  (rst_n),
    .append (keep),
    .rm     (take_rm),
    .stat   (slot_stat)
  );

  rmb_take u_take (
    .clk       (clk),
    .rst_n     (rst_n),
    .take_go   (take_go),
    .in_key    (in_data),
    .stat      (slot_stat),
    .key_rdata (key_rdata),
    .pay_rdata (pay_rdata),
    .key_re    (key_re),
    .key_raddr (key_raddr),
    .pay_re    (pay_re),
    .pay_raddr (pay_raddr),
    .rm        (take_rm),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
